>>> hw/rtl/blhpwm_pkg.sv
// Shared types and constants of the burst-limited heater PWM block.
// Used by blhpwm_cfg, blhpwm_ctrl and burst_limited_heater_pwm; no dependencies.
package blhpwm_pkg;

   localparam int CNT_BITS      = 16;
   localparam int CMP_BITS      = CNT_BITS + 1;
   localparam int TEMP_BITS     = 16;
   localparam int BAND_BITS     = TEMP_BITS + 2;
   localparam int HYST_BITS     = 15;
   localparam int PRE_BITS      = 16;
   localparam int REP_BITS      = 16;
   localparam int DUTY_BITS     = 7;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 16;
   localparam int PROD_BITS     = 24;
   localparam int QPROD_BITS    = 2 * PROD_BITS;

   // Division by one hundred as a multiply by a rounded-up reciprocal. Exact for
   // every product of a 17-bit period and a duty below one hundred.
   localparam logic [PROD_BITS-1:0] DIV100_MUL   = 24'd10737419;
   localparam int                   DIV100_SHIFT = 30;

   localparam logic [DUTY_BITS-1:0] DUTY_FULL = 7'd100;

   // Busy count loaded while the start compare settles after reset or a register write.
   localparam logic [1:0] CFG_SETTLE = 2'd2;

   localparam logic signed [TEMP_BITS-1:0] RST_TARGET_TEMP = 16'sd5000;
   localparam logic [HYST_BITS-1:0]        RST_HYSTERESIS  = 15'd10;
   localparam logic [PRE_BITS-1:0]         RST_PRESCALE    = 16'd79;
   localparam logic [CNT_BITS-1:0]         RST_PERIOD_TOP  = 16'd60000;
   localparam logic [DUTY_BITS-1:0]        RST_DUTY        = 7'd100;
   localparam logic [REP_BITS-1:0]         RST_PULSES      = 16'd4;
   localparam logic [CMP_BITS-1:0]         RST_COMPARE     = 17'd60001;

   typedef enum logic [1:0] {
      OP_TICK   = 2'd0,
      OP_SAMPLE = 2'd1,
      OP_FAULT  = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_TARGET_TEMP = 3'd0,
      CSR_HYSTERESIS  = 3'd1,
      CSR_PRESCALE    = 3'd2,
      CSR_PERIOD_TOP  = 3'd3,
      CSR_DUTY        = 3'd4,
      CSR_PULSES      = 3'd5
   } csr_idx_type;

   typedef struct packed {
      logic signed [TEMP_BITS-1:0] target_temp;
      logic [HYST_BITS-1:0]        hysteresis;
      logic [PRE_BITS-1:0]         prescale_div;
      logic [CNT_BITS-1:0]         period_top;
      logic [REP_BITS-1:0]         pulses_minus_one;
      logic [CMP_BITS-1:0]         start_compare;
   } cfg_type;

   typedef struct packed {
      logic output_enabled;
      logic burst_running;
      logic heater_level;
   } res_type;

endpackage

>>> hw/rtl/blhpwm_cfg.sv
// Configuration registers and the burst start compare value derived from them.
// Depends on blhpwm_pkg.
module blhpwm_cfg (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic [blhpwm_pkg::CSR_ADDR_BITS-1:0]   csr_addr,
   input  logic [blhpwm_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   output blhpwm_pkg::cfg_type                    cfg,
   output logic                                   busy
);

   logic signed [blhpwm_pkg::TEMP_BITS-1:0] target_ff, target_in;
   logic [blhpwm_pkg::HYST_BITS-1:0]        hyst_ff, hyst_in;
   logic [blhpwm_pkg::PRE_BITS-1:0]         prescale_ff, prescale_in;
   logic [blhpwm_pkg::CNT_BITS-1:0]         top_ff, top_in;
   logic [blhpwm_pkg::DUTY_BITS-1:0]        duty_ff, duty_in;
   logic [blhpwm_pkg::REP_BITS-1:0]         pulses_ff, pulses_in;
   logic [1:0]                              settle_ff, settle_in;
   logic [blhpwm_pkg::PROD_BITS-1:0]        prod_ff, prod_in;
   logic [blhpwm_pkg::CMP_BITS-1:0]         start_ff, start_in;
   logic [blhpwm_pkg::CMP_BITS-1:0]         top_plus_one;
   logic [blhpwm_pkg::DUTY_BITS-1:0]        duty_off;
   logic [blhpwm_pkg::QPROD_BITS-1:0]       qprod;

   always_comb begin
      target_in   = target_ff;
      hyst_in     = hyst_ff;
      prescale_in = prescale_ff;
      top_in      = top_ff;
      duty_in     = duty_ff;
      pulses_in   = pulses_ff;
      if (csr_we) begin
         unique case (blhpwm_pkg::csr_idx_type'(csr_addr))
            blhpwm_pkg::CSR_TARGET_TEMP: begin
               target_in = $signed(csr_wdata[blhpwm_pkg::TEMP_BITS-1:0]);
            end
            blhpwm_pkg::CSR_HYSTERESIS: begin
               hyst_in = csr_wdata[blhpwm_pkg::HYST_BITS-1:0];
            end
            blhpwm_pkg::CSR_PRESCALE: begin
               prescale_in = csr_wdata[blhpwm_pkg::PRE_BITS-1:0];
            end
            blhpwm_pkg::CSR_PERIOD_TOP: begin
               top_in = csr_wdata[blhpwm_pkg::CNT_BITS-1:0];
            end
            blhpwm_pkg::CSR_DUTY: begin
               duty_in = csr_wdata[blhpwm_pkg::DUTY_BITS-1:0];
            end
            blhpwm_pkg::CSR_PULSES: begin
               pulses_in = csr_wdata[blhpwm_pkg::REP_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (csr_we) begin
         settle_in = blhpwm_pkg::CFG_SETTLE;
      end else if (settle_ff != 2'd0) begin
         settle_in = settle_ff - 2'd1;
      end else begin
         settle_in = settle_ff;
      end
   end

   // The start compare is recomputed every cycle in two registered steps:
   // (top + 1) * (100 - duty), then the division by one hundred.
   assign top_plus_one = {1'b0, top_ff} + blhpwm_pkg::CMP_BITS'(1);
   assign duty_off     = blhpwm_pkg::DUTY_FULL - duty_ff;
   assign prod_in      = blhpwm_pkg::PROD_BITS'(top_plus_one)
                         * blhpwm_pkg::PROD_BITS'(duty_off);
   assign qprod        = blhpwm_pkg::QPROD_BITS'(prod_ff)
                         * blhpwm_pkg::QPROD_BITS'(blhpwm_pkg::DIV100_MUL);

   always_comb begin
      priority if (duty_ff >= blhpwm_pkg::DUTY_FULL) begin
         start_in = blhpwm_pkg::CMP_BITS'(1);
      end else if (duty_ff == '0) begin
         start_in = top_plus_one;
      end else begin
         start_in = blhpwm_pkg::CMP_BITS'(qprod >> blhpwm_pkg::DIV100_SHIFT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff   <= blhpwm_pkg::RST_TARGET_TEMP;
         hyst_ff     <= blhpwm_pkg::RST_HYSTERESIS;
         prescale_ff <= blhpwm_pkg::RST_PRESCALE;
         top_ff      <= blhpwm_pkg::RST_PERIOD_TOP;
         duty_ff     <= blhpwm_pkg::RST_DUTY;
         pulses_ff   <= blhpwm_pkg::RST_PULSES;
         settle_ff   <= blhpwm_pkg::CFG_SETTLE;
      end else begin
         target_ff   <= target_in;
         hyst_ff     <= hyst_in;
         prescale_ff <= prescale_in;
         top_ff      <= top_in;
         duty_ff     <= duty_in;
         pulses_ff   <= pulses_in;
         settle_ff   <= settle_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      start_ff <= start_in;
   end

   assign busy = (settle_ff != 2'd0);

   assign cfg.target_temp      = target_ff;
   assign cfg.hysteresis       = hyst_ff;
   assign cfg.prescale_div     = prescale_ff;
   assign cfg.period_top       = top_ff;
   assign cfg.pulses_minus_one = pulses_ff;
   assign cfg.start_compare    = start_ff;

endmodule

>>> hw/rtl/blhpwm_ctrl.sv
// Thermostat, burst and PWM counter state, updated once per word.
// Depends on blhpwm_pkg.
module blhpwm_ctrl (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   advance,
   input  blhpwm_pkg::op_type                     op,
   input  logic signed [blhpwm_pkg::TEMP_BITS-1:0] temperature,
   input  blhpwm_pkg::cfg_type                    cfg,
   output blhpwm_pkg::res_type                    res
);

   logic                                running_ff, running_in;
   logic                                oe_ff, oe_in;
   logic [blhpwm_pkg::CNT_BITS-1:0]     step_ff, step_in;
   logic [blhpwm_pkg::PRE_BITS-1:0]     pre_ff, pre_in;
   logic [blhpwm_pkg::REP_BITS-1:0]     rep_ff, rep_in;
   logic [blhpwm_pkg::CMP_BITS-1:0]     cmp_ff, cmp_in;
   logic [blhpwm_pkg::CMP_BITS-1:0]     top_plus_one;
   logic signed [blhpwm_pkg::BAND_BITS-1:0] temp_ext, band_hi, band_lo, target_ext, hyst_ext;

   assign top_plus_one = {1'b0, cfg.period_top} + blhpwm_pkg::CMP_BITS'(1);
   assign temp_ext   = $signed({{2{temperature[blhpwm_pkg::TEMP_BITS-1]}}, temperature});
   assign target_ext = $signed({{2{cfg.target_temp[blhpwm_pkg::TEMP_BITS-1]}},
                                cfg.target_temp});
   assign hyst_ext   = $signed({3'b000, cfg.hysteresis});
   assign band_hi    = target_ext + hyst_ext;
   assign band_lo    = target_ext - hyst_ext;

   always_comb begin
      running_in = running_ff;
      oe_in      = oe_ff;
      step_in    = step_ff;
      pre_in     = pre_ff;
      rep_in     = rep_ff;
      cmp_in     = cmp_ff;
      unique case (op)
         blhpwm_pkg::OP_TICK: begin
            if (running_ff) begin
               if (pre_ff < cfg.prescale_div) begin
                  pre_in = pre_ff + blhpwm_pkg::PRE_BITS'(1);
               end else begin
                  pre_in = '0;
                  if (step_ff >= cfg.period_top) begin
                     step_in = '0;
                     if (rep_ff == '0) begin
                        running_in = 1'b0;
                     end else begin
                        rep_in = rep_ff - blhpwm_pkg::REP_BITS'(1);
                     end
                  end else begin
                     step_in = step_ff + blhpwm_pkg::CNT_BITS'(1);
                  end
               end
            end
         end
         blhpwm_pkg::OP_SAMPLE: begin
            // A burst that ended by itself leaves the output enabled until now.
            if (!running_ff && oe_ff) begin
               oe_in  = 1'b0;
               cmp_in = top_plus_one;
            end
            if (temp_ext > band_hi) begin
               if (running_ff) begin
                  running_in = 1'b0;
                  oe_in      = 1'b0;
                  cmp_in     = top_plus_one;
               end
            end else if (temp_ext < band_lo && !running_ff) begin
               cmp_in     = cfg.start_compare;
               step_in    = '0;
               pre_in     = '0;
               rep_in     = cfg.pulses_minus_one;
               oe_in      = 1'b1;
               running_in = 1'b1;
            end
         end
         blhpwm_pkg::OP_FAULT: begin
            running_in = 1'b0;
            oe_in      = 1'b0;
         end
         blhpwm_pkg::OP_NONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         oe_ff      <= 1'b0;
         step_ff    <= '0;
         pre_ff     <= '0;
         rep_ff     <= '0;
         cmp_ff     <= blhpwm_pkg::RST_COMPARE;
      end else if (advance) begin
         running_ff <= running_in;
         oe_ff      <= oe_in;
         step_ff    <= step_in;
         pre_ff     <= pre_in;
         rep_ff     <= rep_in;
         cmp_ff     <= cmp_in;
      end
   end

   assign res.heater_level   = oe_in && ({1'b0, step_in} >= cmp_in);
   assign res.burst_running  = running_in;
   assign res.output_enabled = oe_in;

`ifndef SYNTH
   // A burst only runs with the output enabled.
   a_run_has_enable: assert property (@(posedge clock) disable iff (reset)
      running_ff |-> oe_ff)
      else $error("burst running with output disabled");

   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable({running_ff, oe_ff, step_ff, pre_ff, rep_ff, cmp_ff}))
      else $error("state changed without a word");
`endif

endmodule

>>> hw/rtl/burst_limited_heater_pwm.sv
// Burst-limited heater PWM controller with a hysteresis thermostat.
// A word on req_ carries an operation in req_tuser: tick, temperature sample
// or fault. Every accepted word gives one word on rsp_ with the heater pin,
// the burst running flag and the output enable after that operation.
// The csr_ port writes the six settings; the user must see that writes are taken
// only while no word is in flight, since the block does not enforce it.
// A word accepted on req_ passes the input register, then the result register,
// before it is shown on rsp_. Throughput is one word per cycle while rsp_tready
// is high and the start compare has settled; the state update is a single pass
// of logic between the two registers. After reset, and after every csr_ write,
// req_tready is low while the burst start compare settles (one multiply per cycle, two steps).
// Reset stops any burst, disables the output and parks the compare at the
// period top plus one. When rsp_tready is low the result word holds, the
// input register takes one more word and req_tready then drops.
// Depends on blhpwm_pkg, blhpwm_cfg and blhpwm_ctrl.
module burst_limited_heater_pwm (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [15:0]                           req_tdata,  // [15:0] temperature
   input  logic [1:0]                            req_tuser,  // [1:0] operation
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [0] heater_level, [1] burst_running, [2] output_enabled, [7:3] zero
   output logic [7:0]                            rsp_tdata,
   input  logic                                  csr_we,
   input  logic [blhpwm_pkg::CSR_ADDR_BITS-1:0]  csr_addr,
   input  logic [blhpwm_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   blhpwm_pkg::cfg_type                     cfg;
   blhpwm_pkg::res_type                     res;
   logic                                    cfg_busy;
   logic                                    advance;
   logic                                    req_take;
   logic                                    in_valid_ff, in_valid_in;
   blhpwm_pkg::op_type                      op_ff;
   logic signed [blhpwm_pkg::TEMP_BITS-1:0] temp_ff;
   logic                                    rsp_valid_ff, rsp_valid_in;
   blhpwm_pkg::res_type                     rsp_res_ff;

   blhpwm_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg),
      .busy      (cfg_busy)
   );

   blhpwm_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .op          (op_ff),
      .temperature (temp_ff),
      .cfg         (cfg),
      .res         (res)
   );

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !cfg_busy && !csr_we && (!in_valid_ff || advance);
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_comb begin
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff   <= blhpwm_pkg::op_type'(req_tuser);
         temp_ff <= $signed(req_tdata[blhpwm_pkg::TEMP_BITS-1:0]);
      end
      if (advance) begin
         rsp_res_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b00000, rsp_res_ff};

`ifndef SYNTH
   a_pin_needs_enable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[2])
      else $error("heater pin high with output disabled");

   a_no_take_after_write: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> !(req_tvalid && req_tready))
      else $error("word taken before the start compare settled");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_tvalid)
      else $error("processed word not presented");
`endif

endmodule
